// ===== sv/c2c_pkg.sv =====
// shared types and constants for the coordinate to compressed column converter
package c2c_pkg;

	localparam logic [10:0] MAX_NONZEROS = 11'd1024;
	localparam logic [10:0] MAX_ROWS     = 11'd1024;
	localparam logic [8:0]  MAX_COLUMNS  = 9'd256;
	localparam logic [8:0]  NUM_COLUMNS_RESET = 9'd256;

	// item kinds
	localparam logic [1:0] K_LOAD  = 2'd0;
	localparam logic [1:0] K_CONV  = 2'd1;
	localparam logic [1:0] K_RDPTR = 2'd2;
	localparam logic [1:0] K_RDENT = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_REJ   = 2'd1;
	localparam logic [1:0] ST_PHASE = 2'd2;

	// sequencer steps
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CLR   = 5'd1;
	localparam logic [4:0] S_CNT_A = 5'd2;
	localparam logic [4:0] S_CNT_B = 5'd3;
	localparam logic [4:0] S_CNT_C = 5'd4;
	localparam logic [4:0] S_PRE_A = 5'd5;
	localparam logic [4:0] S_PRE_B = 5'd6;
	localparam logic [4:0] S_SCT_A = 5'd7;
	localparam logic [4:0] S_SCT_B = 5'd8;
	localparam logic [4:0] S_SCT_C = 5'd9;
	localparam logic [4:0] S_SRT_A = 5'd10;
	localparam logic [4:0] S_SRT_B = 5'd11;
	localparam logic [4:0] S_SRT_C = 5'd12;
	localparam logic [4:0] S_SRT_D = 5'd13;
	localparam logic [4:0] S_FIN   = 5'd14;
	localparam logic [4:0] S_RDP   = 5'd15;
	localparam logic [4:0] S_RDE_A = 5'd16;
	localparam logic [4:0] S_RDE_B = 5'd17;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  col;
		logic [9:0]  row;
	} entry_t;

	typedef struct packed {
		logic [4:0] step;
		logic       i_clr;
		logic       i_one;
		logic       i_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic conv;
		logic idx_gt_n;
		logic none_load;
		logic clr_end;
		logic last_load;
		logic col_ok;
		logic last_col;
		logic last_sort;
		logic sort_skip;
		logic j_zero;
		logic gt;
		logic ent_bad;
	} dp_stat_t;

endpackage

// ===== sv/c2c_ram.sv =====
// generic single write port ram with registered read
module c2c_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/c2c_ctrl.sv =====
// sequencer for load, convert and read items
module c2c_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [1:0]         kind,
	input  c2c_pkg::dp_stat_t  stat,
	output c2c_pkg::dp_cmd_t   cmd,
	output logic               idle
);
	import c2c_pkg::*;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.step  = state_q;
		cmd.i_clr = 1'b0;
		cmd.i_one = 1'b0;
		cmd.i_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (kind)
						K_CONV: begin
							state_d   = S_CLR;
							cmd.i_clr = 1'b1;
						end
						K_RDPTR: if (stat.conv && !stat.idx_gt_n) state_d = S_RDP;
						K_RDENT: if (stat.conv) state_d = S_RDE_A;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				if (stat.clr_end) begin
					cmd.i_clr = 1'b1;
					state_d   = stat.none_load ? S_PRE_A : S_CNT_A;
				end else begin
					cmd.i_inc = 1'b1;
				end
			end
			S_CNT_A: state_d = S_CNT_B;
			S_CNT_B, S_CNT_C: begin
				if (state_q == S_CNT_B && stat.col_ok) begin
					state_d = S_CNT_C;
				end else if (stat.last_load) begin
					cmd.i_clr = 1'b1;
					state_d   = S_PRE_A;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_CNT_A;
				end
			end
			S_PRE_A: state_d = S_PRE_B;
			S_PRE_B: begin
				if (!stat.last_col) begin
					cmd.i_inc = 1'b1;
					state_d   = S_PRE_A;
				end else if (stat.none_load) begin
					state_d = S_FIN;
				end else begin
					cmd.i_clr = 1'b1;
					state_d   = S_SCT_A;
				end
			end
			S_SCT_A: state_d = S_SCT_B;
			S_SCT_B, S_SCT_C: begin
				if (state_q == S_SCT_B && stat.col_ok) begin
					state_d = S_SCT_C;
				end else if (!stat.last_load) begin
					cmd.i_inc = 1'b1;
					state_d   = S_SCT_A;
				end else if (stat.sort_skip) begin
					state_d = S_FIN;
				end else begin
					cmd.i_one = 1'b1;
					state_d   = S_SRT_A;
				end
			end
			S_SRT_A: state_d = S_SRT_B;
			S_SRT_B: state_d = S_SRT_C;
			S_SRT_C, S_SRT_D: begin
				if (state_q == S_SRT_C && !stat.j_zero) begin
					state_d = S_SRT_D;
				end else if (state_q == S_SRT_D && stat.gt) begin
					state_d = S_SRT_C;
				end else if (stat.last_sort) begin
					state_d = S_FIN;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_SRT_A;
				end
			end
			S_FIN:   state_d = S_IDLE;
			S_RDP:   state_d = S_IDLE;
			S_RDE_A: state_d = stat.ent_bad ? S_IDLE : S_RDE_B;
			S_RDE_B: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = (state_q == S_IDLE);
endmodule

// ===== sv/c2c_dpath.sv =====
// stores, counters and result register of the converter
module c2c_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  c2c_pkg::dp_cmd_t   cmd,
	output c2c_pkg::dp_stat_t  stat,
	input  logic               acc,
	input  logic [1:0]         kind,
	input  logic [9:0]         row,
	input  logic [7:0]         col,
	input  logic [63:0]        value,
	input  logic [10:0]        index,
	input  logic [8:0]         num_columns,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [10:0]        row_or_pointer,
	output logic [63:0]        entry_value,
	output logic [10:0]        entry_total
);
	import c2c_pkg::*;

	logic [8:0]  n;
	logic [10:0] cnt_q, i_q, sum_q, idx_q, base, i_nx;
	logic [9:0]  j_q;
	logic        conv_q, ld_ok, set_valid;
	entry_t      tmp_q, load_rd, sort_rd, ld_wdata, so_wdata;
	logic [10:0] starts_rd, fill_rd, st_wdata, fl_wdata;
	logic [8:0]  st_raddr, st_waddr, fl_raddr, fl_waddr, col_ix;
	logic [9:0]  so_raddr, so_waddr;
	logic        st_we, fl_we, so_we, ld_we;

	always_comb begin
		if (num_columns == 9'd0) n = 9'd1;
		else if (num_columns > MAX_COLUMNS) n = MAX_COLUMNS;
		else n = num_columns;
	end

	assign base     = conv_q ? 11'd0 : cnt_q;
	assign ld_ok    = (base < MAX_NONZEROS) && ({1'b0, row} < MAX_ROWS) && ({1'b0, col} < n);
	assign ld_we    = acc && (cmd.step == S_IDLE) && (kind == K_LOAD) && ld_ok;
	assign ld_wdata = '{value: value, col: col, row: row};
	assign col_ix   = {1'b0, load_rd.col};
	assign i_nx     = i_q + 11'd1;

	c2c_ram #(.WIDTH($bits(entry_t)), .DEPTH(1024)) u_load (
		.clk(clk), .we(ld_we), .waddr(base[9:0]), .wdata(ld_wdata),
		.raddr(i_q[9:0]), .rdata(load_rd));
	c2c_ram #(.WIDTH(11), .DEPTH(257)) u_starts (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(starts_rd));
	c2c_ram #(.WIDTH(11), .DEPTH(257)) u_fill (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fill_rd));
	c2c_ram #(.WIDTH($bits(entry_t)), .DEPTH(1024)) u_sorted (
		.clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(sort_rd));

	// status toward the sequencer
	always_comb begin
		stat.conv      = conv_q;
		stat.idx_gt_n  = index > {2'b00, n};
		stat.none_load = (cnt_q == 11'd0);
		stat.clr_end   = (i_q == {2'b00, MAX_COLUMNS});
		stat.last_load = (i_nx == cnt_q);
		stat.col_ok    = col_ix < n;
		stat.last_col  = (i_nx == {2'b00, n});
		stat.last_sort = (i_nx == sum_q);
		stat.sort_skip = (sum_q < 11'd2);
		stat.j_zero    = (j_q == 10'd0);
		stat.gt        = {sort_rd.col, sort_rd.row} > {tmp_q.col, tmp_q.row};
		stat.ent_bad   = (idx_q >= starts_rd) || (idx_q >= MAX_NONZEROS);
	end

	// memory port steering by step
	always_comb begin
		st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
		fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
		so_we = 1'b0; so_waddr = '0; so_wdata = tmp_q; so_raddr = '0;
		case (cmd.step)
			S_IDLE: st_raddr = (kind == K_RDENT) ? n : index[8:0];
			S_CLR: begin
				st_we = 1'b1; st_waddr = i_q[8:0];
				fl_we = 1'b1; fl_waddr = i_q[8:0];
			end
			S_CNT_B: st_raddr = col_ix + 9'd1;
			S_CNT_C: begin
				st_we    = 1'b1;
				st_waddr = col_ix + 9'd1;
				st_wdata = starts_rd + 11'd1;
			end
			S_PRE_A: st_raddr = i_q[8:0] + 9'd1;
			S_PRE_B: begin
				st_we = 1'b1; st_waddr = i_q[8:0] + 9'd1; st_wdata = sum_q + starts_rd;
				fl_we = 1'b1; fl_waddr = i_q[8:0] + 9'd1; fl_wdata = sum_q + starts_rd;
			end
			S_SCT_B: fl_raddr = col_ix;
			S_SCT_C: begin
				fl_we = 1'b1; fl_waddr = col_ix; fl_wdata = fill_rd + 11'd1;
				so_we = 1'b1; so_waddr = fill_rd[9:0]; so_wdata = load_rd;
			end
			S_SRT_A: so_raddr = i_q[9:0];
			S_SRT_C: begin
				if (j_q == 10'd0) begin
					so_we = 1'b1;
				end else begin
					so_raddr = j_q - 10'd1;
				end
			end
			S_SRT_D: begin
				so_we    = 1'b1;
				so_waddr = j_q;
				so_wdata = stat.gt ? sort_rd : tmp_q;
			end
			S_RDE_A: so_raddr = idx_q[9:0];
			default: st_raddr = '0;
		endcase
	end

	// steps that complete a result
	always_comb begin
		set_valid = 1'b0;
		case (cmd.step)
			S_IDLE: begin
				if (acc) begin
					case (kind)
						K_LOAD:  set_valid = 1'b1;
						K_RDPTR: set_valid = !conv_q || stat.idx_gt_n;
						K_RDENT: set_valid = !conv_q;
						default: set_valid = 1'b0;
					endcase
				end
			end
			S_FIN, S_RDP, S_RDE_B: set_valid = 1'b1;
			S_RDE_A: set_valid = stat.ent_bad;
			default: set_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			conv_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_one) i_q <= 11'd1;
			else if (cmd.i_inc) i_q <= i_nx;

			if (cmd.step == S_SRT_B) j_q <= i_q[9:0];
			else if (cmd.step == S_SRT_D && stat.gt) j_q <= j_q - 10'd1;

			if (cmd.step == S_CLR) sum_q <= '0;
			else if (cmd.step == S_PRE_B) sum_q <= sum_q + starts_rd;

			out_valid <= set_valid | (out_valid & ~out_ready);

			if (cmd.step == S_IDLE && acc && kind == K_LOAD) begin
				conv_q <= 1'b0;
				cnt_q  <= ld_ok ? base + 11'd1 : base;
			end else if (cmd.step == S_FIN) begin
				conv_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.step == S_SRT_B) tmp_q <= sort_rd;
		if (cmd.step == S_IDLE && acc) idx_q <= index;
		case (cmd.step)
			S_IDLE: begin
				if (acc) begin
					row_or_pointer <= '0;
					entry_value    <= '0;
					case (kind)
						K_LOAD: begin
							status      <= ld_ok ? ST_OK : ST_REJ;
							entry_total <= ld_ok ? base + 11'd1 : base;
						end
						default: begin
							status      <= !conv_q ? ST_PHASE : ST_REJ;
							entry_total <= cnt_q;
						end
					endcase
				end
			end
			S_FIN: begin
				status         <= ST_OK;
				row_or_pointer <= '0;
				entry_value    <= '0;
				entry_total    <= cnt_q;
			end
			S_RDP: begin
				status         <= ST_OK;
				row_or_pointer <= starts_rd;
				entry_value    <= '0;
				entry_total    <= cnt_q;
			end
			S_RDE_A: begin
				status         <= ST_REJ;
				row_or_pointer <= '0;
				entry_value    <= '0;
				entry_total    <= cnt_q;
			end
			S_RDE_B: begin
				status         <= ST_OK;
				row_or_pointer <= {1'b0, sort_rd.row};
				entry_value    <= sort_rd.value;
				entry_total    <= cnt_q;
			end
			default: status <= status;
		endcase
	end
endmodule

// ===== sv/coo_to_csc_converter_unit.sv =====
// top level of the coordinate to compressed sparse column converter
// usage:
//  - input items arrive on s_tvalid/s_tready with the kind in s_tuser:
//    load one nonzero, convert, read a column start, read a sorted entry
//  - every item returns exactly one result item on m_tvalid/m_tready,
//    status in m_tuser, pointer or row, value and entry total in m_tdata
//  - a load, a wrong phase read and a rejected column start read are
//    answered from the idle step; a sorted entry read beyond the entries from S_RDE_A
//  - a column start read passes through S_RDP, a sorted entry read through
//    S_RDE_A and S_RDE_B, set by the registered read of the start and sorted stores
//  - convert clears the start and fill stores, counts the entries per column,
//    forms the column starts, scatters the entries into the sorted store and
//    insertion sorts them; the single read port of the sorted store sets the sort pace
//  - one item is in work at a time; a new item is taken in the cycle its
//    result is taken or while the result register is empty
//  - a stalled receiver holds the result and blocks further input items
//  - reset empties the store, clears the converted mark and sets the
//    column count to 256; no clearing pass is needed
//  - num_columns lives at byte address 0 of the apb port
module coo_to_csc_converter_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // row[9:0] col[17:10] value[81:18] index[92:82] zero pad
	input  logic [1:0]   s_tuser,  // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // row_or_pointer[10:0] entry_value[74:11] entry_total[85:75]
	output logic [1:0]   m_tuser,  // status[1:0]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import c2c_pkg::*;

	logic [8:0]  num_columns_q;
	logic        idle, acc;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [1:0]  status;
	logic [10:0] row_or_pointer, entry_total;
	logic [63:0] entry_value;

	// config register, zero wait apb
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {23'd0, num_columns_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_columns_q <= NUM_COLUMNS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			num_columns_q <= pwdata[8:0];
		end
	end

	// take an item only when the sequencer is free and the result slot is empty or drains
	assign s_tready = idle && (!m_tvalid || m_tready);
	assign acc      = s_tvalid && s_tready;

	c2c_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .acc(acc), .kind(s_tuser),
		.stat(stat), .cmd(cmd), .idle(idle));

	c2c_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.acc(acc), .kind(s_tuser),
		.row(s_tdata[9:0]), .col(s_tdata[17:10]),
		.value(s_tdata[81:18]), .index(s_tdata[92:82]),
		.num_columns(num_columns_q), .out_ready(m_tready),
		.out_valid(m_tvalid), .status(status),
		.row_or_pointer(row_or_pointer), .entry_value(entry_value),
		.entry_total(entry_total));

	assign m_tuser = status;
	assign m_tdata = {2'b00, entry_total, entry_value, row_or_pointer};
endmodule
